// ===== rtl/ssd_pkg.sv =====
package ssd_pkg;

	// Photodiode readings that take part in the lit decision (at most four fields exist)
	localparam int unsigned SENSOR_COUNT = 4;
	localparam int unsigned READING_FIELDS = 4;

	localparam int unsigned LEVEL_W = 10;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 10'd100;
	localparam logic [TIME_W-1:0] MIN_DARK_RESET = 32'd10000;

	typedef enum logic [0:0] {
		REG_BRIGHT_THRESHOLD = 1'b0,
		REG_MIN_DARK_MS      = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] light_level_0;
		logic [LEVEL_W-1:0] light_level_1;
		logic [LEVEL_W-1:0] light_level_2;
		logic [LEVEL_W-1:0] light_level_3;
		logic [TIME_W-1:0]  now_ms;
		logic [INDEX_W-1:0] history_index;
	} sample_t;

	typedef struct packed {
		logic              lit;
		logic              daytime;
		logic              sunrise_logged;
		logic              sunset_logged;
		logic [TIME_W-1:0] logged_time;
		logic              candidate_open;
		logic [TIME_W-1:0] rise_at_index;
		logic              rise_valid;
		logic [TIME_W-1:0] set_at_index;
		logic              set_valid;
	} result_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] bright_threshold;
		logic [TIME_W-1:0]  min_dark_ms;
	} cfg_t;

	// Outcome of one sample, before it is committed
	typedef struct packed {
		logic              lit;
		logic              daytime;
		logic              rise_push;
		logic              set_push;
		logic [TIME_W-1:0] logged_time;
		logic              candidate_open;
	} decision_t;

	typedef struct packed {
		logic              push;
		logic [TIME_W-1:0] value;
	} hist_push_t;

endpackage

// ===== rtl/ssd_regs.sv =====
module ssd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssd_pkg::PADDR_W-1:0] paddr,
	input  logic [ssd_pkg::PDATA_W-1:0] pwdata,
	output logic [ssd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output ssd_pkg::cfg_t               cfg
);
	import ssd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;

	assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_threshold <= THRESHOLD_RESET;
			cfg_q.min_dark_ms      <= MIN_DARK_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_BRIGHT_THRESHOLD: cfg_q.bright_threshold <= pwdata[LEVEL_W-1:0];
				REG_MIN_DARK_MS:      cfg_q.min_dark_ms <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_BRIGHT_THRESHOLD: prdata = PDATA_W'(cfg_q.bright_threshold);
			REG_MIN_DARK_MS:      prdata = PDATA_W'(cfg_q.min_dark_ms);
			default:              prdata = '0;
		endcase
	end

endmodule

// ===== rtl/ssd_decide.sv =====
module ssd_decide (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ssd_pkg::sample_t    item,
	input  ssd_pkg::cfg_t       cfg,
	output ssd_pkg::decision_t  dec
);
	import ssd_pkg::*;

	logic              day_q;
	logic              cand_q;
	logic [TIME_W-1:0] cand_time_q;

	logic [LEVEL_W-1:0] levels [READING_FIELDS];
	logic               lit;
	logic [TIME_W-1:0]  dark_span;
	logic               dark_enough;
	logic               day_d;
	logic               cand_d;
	logic [TIME_W-1:0]  cand_time_d;

	assign levels[0] = item.light_level_0;
	assign levels[1] = item.light_level_1;
	assign levels[2] = item.light_level_2;
	assign levels[3] = item.light_level_3;

	always_comb begin
		lit = 1'b0;
		for (int i = 0; i < READING_FIELDS; i++) begin
			if (i < SENSOR_COUNT && levels[i] > cfg.bright_threshold)
				lit = 1'b1;
		end
	end

	// darkness measured modulo 2^32
	assign dark_span   = item.now_ms - cand_time_q;
	assign dark_enough = dark_span >= cfg.min_dark_ms;

	always_comb begin
		day_d           = day_q;
		cand_d          = cand_q;
		cand_time_d     = cand_time_q;
		dec.rise_push   = 1'b0;
		dec.set_push    = 1'b0;
		dec.logged_time = '0;
		if (lit && !day_q) begin
			day_d           = 1'b1;
			dec.rise_push   = 1'b1;
			dec.logged_time = item.now_ms;
		end else if (!lit && day_q) begin
			if (!cand_q) begin
				cand_d      = 1'b1;
				cand_time_d = item.now_ms;
			end else if (dark_enough) begin
				dec.set_push    = 1'b1;
				dec.logged_time = cand_time_q;
				cand_d          = 1'b0;
				cand_time_d     = '0;
				day_d           = 1'b0;
			end
		end else if (lit && day_q) begin
			cand_d      = 1'b0;
			cand_time_d = '0;
		end
		dec.lit            = lit;
		dec.daytime        = day_d;
		dec.candidate_open = cand_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q       <= 1'b0;
			cand_q      <= 1'b0;
			cand_time_q <= '0;
		end else if (fire) begin
			day_q       <= day_d;
			cand_q      <= cand_d;
			cand_time_q <= cand_time_d;
		end
	end

	// a candidate only lives during day
	assert property (@(posedge clk) disable iff (!arst_n) cand_q |-> day_q)
		else $error("sunset candidate pending at night");

endmodule

// ===== rtl/ssd_history.sv =====
module ssd_history #(
	parameter int unsigned DEPTH = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  ssd_pkg::hist_push_t           push,
	input  logic [ssd_pkg::INDEX_W-1:0]   index,
	output logic [ssd_pkg::TIME_W-1:0]    value,
	output logic                          valid
);
	import ssd_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);

	logic [TIME_W-1:0] vals_q [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [TIME_W-1:0] vals_d [DEPTH];
	logic [DEPTH-1:0]  vld_d;
	logic [IW-1:0]     sel;
	logic              in_range;

	// oldest entry drops out of slot 0, newest lands in the top slot
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			vals_d[i] = vals_q[i];
			vld_d[i]  = vld_q[i];
		end
		if (push.push) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				vals_d[i] = vals_q[i+1];
				vld_d[i]  = vld_q[i+1];
			end
			vals_d[DEPTH-1] = push.value;
			vld_d[DEPTH-1]  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= vld_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DEPTH; i++)
				vals_q[i] <= vals_d[i];
		end
	end

	// read after this sample's update
	assign in_range = 32'(index) < 32'(DEPTH);
	assign sel      = IW'(index);
	assign valid    = in_range & vld_d[sel];
	assign value    = valid ? vals_d[sel] : '0;

endmodule

// ===== rtl/sunrise_sunset_detector.sv =====
// Sunrise / sunset detector. Each sample request carries four photodiode
// readings, a wrapping millisecond timestamp and a history slot to report.
// A sample is lit when any reading is strictly above bright_threshold
// (register 0, byte address 0, reset 100). A lit sample at night logs a
// sunrise at once; a dark sample during day opens a sunset candidate, which
// is logged as a sunset at its opening time once the darkness has lasted
// min_dark_ms (register 1, byte address 4, reset 10000) modulo 2^32, and is
// dropped by renewed light. The newest HISTORY_DEPTH sunrises and sunsets are
// kept in shift histories (newest in slot HISTORY_DEPTH-1, empty after reset);
// each result reports the requested slot after the sample's own update, with
// zero and a cleared valid bit for empty or out-of-range slots. Throughput is
// one sample per clock while the result port does not stall; a sample's
// result passes through the input register and then the result register,
// with the single decision stage between them. Back-pressure on the result
// port stalls only once both registers are full. Write configuration only
// while idle.
module sunrise_sunset_detector #(
	parameter int unsigned HISTORY_DEPTH = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssd_pkg::PADDR_W-1:0] paddr,
	input  logic [ssd_pkg::PDATA_W-1:0] pwdata,
	output logic [ssd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  ssd_pkg::sample_t            sample,
	output logic                        result_valid,
	input  logic                        result_ready,
	output ssd_pkg::result_t            result
);
	import ssd_pkg::*;

	cfg_t       cfg;
	decision_t  dec;
	hist_push_t rise_push;
	hist_push_t set_push;
	sample_t    item_s1;
	logic       valid_s1;
	result_t    result_q;
	logic       result_valid_q;
	logic       advance;
	logic [TIME_W-1:0] rise_val;
	logic [TIME_W-1:0] set_val;
	logic       rise_vld;
	logic       set_vld;

	ssd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The held sample moves on whenever the result register is free or draining
	assign advance      = valid_s1 & (~result_valid_q | result_ready);
	assign sample_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (sample_valid && sample_ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready)
			item_s1 <= sample;
	end

	// Day/night state and the candidate; commits only when the sample moves on
	ssd_decide u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.dec    (dec)
	);

	// Both histories are fed the logged time: the sample time for a sunrise,
	// the candidate opening time for a sunset
	assign rise_push.push  = dec.rise_push;
	assign rise_push.value = dec.logged_time;
	assign set_push.push   = dec.set_push;
	assign set_push.value  = dec.logged_time;

	ssd_history #(.DEPTH(HISTORY_DEPTH)) u_rise_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.push   (rise_push),
		.index  (item_s1.history_index),
		.value  (rise_val),
		.valid  (rise_vld)
	);

	ssd_history #(.DEPTH(HISTORY_DEPTH)) u_set_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.push   (set_push),
		.index  (item_s1.history_index),
		.value  (set_val),
		.valid  (set_vld)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (advance)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.lit            <= dec.lit;
			result_q.daytime        <= dec.daytime;
			result_q.sunrise_logged <= dec.rise_push;
			result_q.sunset_logged  <= dec.set_push;
			result_q.logged_time    <= dec.logged_time;
			result_q.candidate_open <= dec.candidate_open;
			result_q.rise_at_index  <= rise_val;
			result_q.rise_valid     <= rise_vld;
			result_q.set_at_index   <= set_val;
			result_q.set_valid      <= set_vld;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a sample logs one event at most
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> !(result_q.sunrise_logged && result_q.sunset_logged))
		else $error("sunrise and sunset logged by one sample");

	// a sunrise leaves it day, a sunset leaves it night with no candidate
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.sunrise_logged) |-> result_q.daytime)
		else $error("sunrise logged but not day");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.sunset_logged)
		|-> (!result_q.daytime && !result_q.candidate_open))
		else $error("sunset logged but day or candidate left open");

	// the time field is quiet when nothing was logged
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.sunrise_logged && !result_q.sunset_logged)
		|-> (result_q.logged_time == '0))
		else $error("logged time set with no event");

endmodule
